[hdl/crus_pkg.sv]
package crus_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int RESULT_CAP = 32;
    localparam int COORD_W = 16;
    localparam int SUM_W = 22;
    localparam int DIST2_W = 35;
    localparam int RAD_W = 17;
    localparam int IDX_W = 5;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_DIV = 3'd1;
    localparam logic [2:0] ST_DIST = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    typedef struct packed {
        logic start;
        logic is_sqrt;
        logic [DIST2_W-1:0] num;
        logic [RAD_W-1:0] den;
    } crus_op_t;

endpackage

[hdl/crus_store.sv]
module crus_store
    import crus_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF,
    parameter int AW = 6
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [3*COORD_W-1:0]     wdata,
    input  logic [AW-1:0]            raddr,
    output logic [3*COORD_W-1:0]     rdata
);

    logic [3*COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/crus_unit.sv]
// Shared bit-serial unit: restoring divide (one quotient bit a cycle) or
// integer square root (one result bit a cycle).
module crus_unit
    import crus_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  crus_op_t             op,
    output logic                 busy,
    output logic [DIST2_W-1:0]   result
);

    localparam int CW = 6;

    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 sqrt_reg;
    logic [DIST2_W-1:0]   q_reg;
    logic [DIST2_W+1:0]   rem_reg;
    logic [DIST2_W+1:0]   v_reg;
    logic [RAD_W-1:0]     den_reg;
    logic [DIST2_W+1:0]   trial;
    logic [DIST2_W+1:0]   rem_sh;
    logic [DIST2_W-1:0]   q_sh;

    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh = {rem_reg[DIST2_W-1:0], v_reg[DIST2_W+1 -: 2]};
            q_sh = {q_reg[DIST2_W-2:0], 1'b0};
            trial = {q_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[DIST2_W:0], v_reg[DIST2_W+1]};
            q_sh = {q_reg[DIST2_W-2:0], 1'b0};
            trial = {{(DIST2_W+2-RAD_W){1'b0}}, den_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (op.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= op.is_sqrt ? CW'(18) : CW'(DIST2_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.start)
        begin
            sqrt_reg <= op.is_sqrt;
            q_reg <= '0;
            rem_reg <= '0;
            den_reg <= op.den;
            // Square root consumes pairs from a 36-bit left-aligned word.
            v_reg <= op.is_sqrt ? {1'b0, op.num, 1'b0} : {op.num, 2'b00};
        end
        else if (busy_reg)
        begin
            v_reg <= sqrt_reg ? {v_reg[DIST2_W-1:0], 2'b00} : {v_reg[DIST2_W:0], 1'b0};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                q_reg <= q_sh | DIST2_W'(1);
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg <= q_sh;
            end
        end
    end

    assign busy = busy_reg;
    assign result = q_reg;

endmodule

[hdl/centroid_radius_unit_scaling_core.sv]
// Centroid and bounding-radius unit scaling core.
// Vertices arrive on the slave stream, one request per vertex, with tlast
// marking the final vertex of a set. Each vertex up to MAX_VERTICES is
// written to an on-chip store and summed as it is accepted, so loading runs
// at one vertex per cycle; later vertices of a set are dropped and flagged.
// On tlast the block stops accepting requests and works on the set: the
// centroid comes from three serial divides by the count, the radius from a
// serial square root per stored vertex, and each result needs three serial
// divides by the radius plus a store read and a bus transfer, all on one
// shared divide/square-root unit. With a zero radius the divides are skipped
// and the scaled offsets are zero. Results leave on the master stream through
// one output register; while the receiver holds tready low the block waits
// with that result on the bus. After the final result (tlast high) the sums
// and flags clear and the next set may be loaded. Reset clears all control
// state; the vertex store holds no reset value and is only read where it was
// written for the current set.
module centroid_radius_unit_scaling_core
    import crus_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // pos_x, pos_y, pos_z
    input  logic          s_tlast,   // last_vertex
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [119:0]  m_tdata,   // vertex_index, scaled_x/y/z, centroid_x/y/z,
                                     // bound_radius, 2 zero bits
    output logic [1:0]    m_tuser,   // radius_zero, dropped_any
    output logic          m_tlast    // last_result
);

    localparam int AW = $clog2(MAX_VERTICES + 1);
    localparam int SAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [2:0]          state_reg;
    logic [AW-1:0]       count_reg;
    logic                ovf_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [COORD_W-1:0] cen_reg [3];
    logic signed [COORD_W-1:0] scl_reg [3];
    logic [RAD_W-1:0]    maxd_reg;
    logic [AW-1:0]       idx_reg;
    logic [1:0]          axis_reg;
    logic                issued_reg;
    logic                rd_ok_reg;
    logic                rd_clr;
    logic [3*COORD_W-1:0] rdata;
    logic [SAW-1:0]      raddr;
    logic [SAW-1:0]      waddr;
    logic                accept;
    logic                full;
    crus_op_t            op;
    logic                ubusy;
    logic [DIST2_W-1:0]  ures;
    logic [AW-1:0]       n_out;
    logic signed [COORD_W:0] diff [3];
    logic [COORD_W:0]    mag_sel;
    logic [2*COORD_W+1:0] sq [3];
    logic [DIST2_W-1:0]  d2;
    logic [SUM_W-1:0]    smag;
    logic                sneg;

    assign full = (count_reg == AW'(MAX_VERTICES));
    assign s_tready = (state_reg == ST_LOAD);
    assign accept = s_tvalid && s_tready;
    assign raddr = SAW'(idx_reg);
    assign waddr = SAW'(count_reg);
    assign n_out = (int'(count_reg) > RESULT_CAP) ? AW'(RESULT_CAP) : count_reg;

    // The store read is registered, so its output is stale in the cycle after the read address moves.
    assign rd_clr = ((state_reg == ST_DIV) && issued_reg && !ubusy && (axis_reg == 2'd2))
                 || ((state_reg == ST_DIST) && issued_reg && !ubusy)
                 || ((state_reg == ST_EMIT) && m_tready);

    crus_store #(.DEPTH(MAX_VERTICES), .AW(SAW)) u_store (
        .clk(clk), .we(accept && !full), .waddr(waddr), .wdata(s_tdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = $signed({rdata[a*COORD_W+COORD_W-1], rdata[a*COORD_W +: COORD_W]})
                    - $signed({cen_reg[a][COORD_W-1], cen_reg[a]});
            sq[a] = $unsigned(34'(diff[a]) * 34'(diff[a]));
        end
        d2 = DIST2_W'(sq[0]) + DIST2_W'(sq[1]) + DIST2_W'(sq[2]);
        mag_sel = diff[axis_reg][COORD_W] ? $unsigned(-diff[axis_reg])
                                          : $unsigned(diff[axis_reg]);
        sneg = sum_reg[axis_reg][SUM_W-1];
        smag = sneg ? -sum_reg[axis_reg] : sum_reg[axis_reg];
        op = '0;
        if (!ubusy && !issued_reg)
        begin
            case (state_reg)
                ST_DIV:
                begin
                    op.start = 1'b1;
                    op.num = DIST2_W'(smag);
                    op.den = RAD_W'(count_reg);
                end
                ST_DIST:
                begin
                    op.start = rd_ok_reg;
                    op.is_sqrt = 1'b1;
                    op.num = d2;
                end
                ST_SCALE:
                begin
                    op.start = rd_ok_reg && (maxd_reg != '0);
                    op.num = DIST2_W'({mag_sel, 14'b0});
                    op.den = maxd_reg;
                end
                default:
                begin
                    op = '0;
                end
            endcase
        end
    end

    crus_unit u_unit (.clk(clk), .rst_n(rst_n), .op(op), .busy(ubusy), .result(ures));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            maxd_reg <= '0;
            idx_reg <= '0;
            axis_reg <= '0;
            issued_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            m_tvalid <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
                cen_reg[a] <= '0;
                scl_reg[a] <= '0;
            end
        end
        else
        begin
            rd_ok_reg <= !rd_clr;
            if (op.start)
            begin
                issued_reg <= 1'b1;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + 1'b1;
                            for (int a = 0; a < 3; a++)
                            begin
                                sum_reg[a] <= sum_reg[a]
                                    + SUM_W'($signed(s_tdata[a*COORD_W +: COORD_W]));
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            state_reg <= ST_DIV;
                            axis_reg <= '0;
                            issued_reg <= 1'b0;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (issued_reg && !ubusy)
                    begin
                        cen_reg[axis_reg] <= sneg ? -COORD_W'(ures) : COORD_W'(ures);
                        issued_reg <= 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_DIST;
                            idx_reg <= '0;
                            maxd_reg <= '0;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                end
                ST_DIST:
                begin
                    if (issued_reg && !ubusy)
                    begin
                        issued_reg <= 1'b0;
                        if (RAD_W'(ures) > maxd_reg)
                        begin
                            maxd_reg <= RAD_W'(ures);
                        end
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            state_reg <= ST_SCALE;
                            idx_reg <= '0;
                            axis_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_SCALE:
                begin
                    if (rd_ok_reg && (maxd_reg == '0) && !issued_reg)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            scl_reg[a] <= '0;
                        end
                        state_reg <= ST_EMIT;
                        m_tvalid <= 1'b1;
                    end
                    else if (issued_reg && !ubusy)
                    begin
                        issued_reg <= 1'b0;
                        scl_reg[axis_reg] <= diff[axis_reg][COORD_W]
                            ? -COORD_W'(ures) : COORD_W'(ures);
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_EMIT;
                            m_tvalid <= 1'b1;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        m_tvalid <= 1'b0;
                        issued_reg <= 1'b0;
                        axis_reg <= '0;
                        if (idx_reg + 1'b1 == n_out)
                        begin
                            state_reg <= ST_LOAD;
                            count_reg <= '0;
                            ovf_reg <= 1'b0;
                            maxd_reg <= '0;
                            idx_reg <= '0;
                            for (int a = 0; a < 3; a++)
                            begin
                                sum_reg[a] <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_SCALE;
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tdata = {2'b00, maxd_reg, cen_reg[2], cen_reg[1], cen_reg[0],
                      scl_reg[2], scl_reg[1], scl_reg[0], IDX_W'(idx_reg)};
    assign m_tuser = {ovf_reg, (maxd_reg == '0)};
    assign m_tlast = (idx_reg + 1'b1 == n_out);

    a_tready_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("input open while result pending");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= AW'(MAX_VERTICES)) else $error("count beyond capacity");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (state_reg == ST_EMIT)) else $error("valid outside emit");

endmodule

[test/centroid_radius_unit_scaling_core_tb.sv]
`timescale 1ns / 1ps

// Vertex sets go in on the slave stream; each set ends with tlast. The bench
// keeps its own vertex store and sums and, when a final vertex is accepted,
// computes the centroid, the bounding radius and the scaled vertices. Each
// result on the master stream is checked field by field against the oldest
// prediction. The run passes through four traffic phases: none of the streams
// idle, then the sender idles, then the receiver stalls, then both do.
module centroid_radius_unit_scaling_core_tb;
    import crus_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        bit          last;
    } vertex_req_t;

    typedef struct {
        logic [4:0]  index;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [16:0] radius;
        bit          radius_zero;
        bit          dropped;
        bit          last;
    } scaled_vertex_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [47:0]   s_tdata = '0;
    logic          s_tlast = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [119:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;

    vertex_req_t    pending_q[$];
    scaled_vertex_t scaled_q[$];
    int             total_requests;
    int             accepted = 0;
    int             errors = 0;
    int             cycles = 0;

    // The bench's own copy of the block state.
    int  held_x[MAX_VERTICES_DEF];
    int  held_y[MAX_VERTICES_DEF];
    int  held_z[MAX_VERTICES_DEF];
    int  acc_x = 0;
    int  acc_y = 0;
    int  acc_z = 0;
    int  held_count = 0;
    bit  overflowed = 1'b0;

    centroid_radius_unit_scaling_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Integer square root, rounded down, by the digit-by-digit method.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos >>= 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v -= root + bitpos;
                root = (root >> 1) + bitpos;
            end
            else
                root >>= 1;
            bitpos >>= 2;
        end
        return root;
    endfunction

    // Offset over radius in Q1.14, truncated toward zero.
    function automatic logic [15:0] unit_scale(int offset, int radius);
        longint mag;
        longint q;
        mag = (offset < 0) ? -longint'(offset) : longint'(offset);
        q = (mag <<< 14) / radius;
        return (offset < 0) ? 16'(-q) : 16'(q);
    endfunction

    // Account for one accepted vertex; a final vertex produces the whole set.
    task automatic absorb_vertex(vertex_req_t v);
        int cx;
        int cy;
        int cz;
        int radius;
        longint dx;
        longint dy;
        longint dz;
        longint unsigned d;
        int n;
        scaled_vertex_t r;
        if (held_count < MAX_VERTICES_DEF)
        begin
            held_x[held_count] = $signed(v.x);
            held_y[held_count] = $signed(v.y);
            held_z[held_count] = $signed(v.z);
            acc_x += $signed(v.x);
            acc_y += $signed(v.y);
            acc_z += $signed(v.z);
            held_count++;
        end
        else
            overflowed = 1'b1;
        if (!v.last)
            return;
        cx = acc_x / held_count;
        cy = acc_y / held_count;
        cz = acc_z / held_count;
        radius = 0;
        for (int i = 0; i < held_count; i++)
        begin
            dx = held_x[i] - cx;
            dy = held_y[i] - cy;
            dz = held_z[i] - cz;
            d = floor_sqrt(dx * dx + dy * dy + dz * dz);
            if (int'(d) > radius)
                radius = int'(d);
        end
        n = (held_count < RESULT_CAP) ? held_count : RESULT_CAP;
        for (int i = 0; i < n; i++)
        begin
            r.index = 5'(i);
            r.sx = (radius == 0) ? 16'd0 : unit_scale(held_x[i] - cx, radius);
            r.sy = (radius == 0) ? 16'd0 : unit_scale(held_y[i] - cy, radius);
            r.sz = (radius == 0) ? 16'd0 : unit_scale(held_z[i] - cz, radius);
            r.cx = 16'(cx);
            r.cy = 16'(cy);
            r.cz = 16'(cz);
            r.radius = 17'(radius);
            r.radius_zero = (radius == 0);
            r.dropped = overflowed;
            r.last = (i + 1 == n);
            scaled_q.push_back(r);
        end
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        held_count = 0;
        overflowed = 1'b0;
    endtask

    function automatic logic [15:0] rand_coord(int mode, logic [15:0] base);
        case (mode)
            0: return 16'($urandom);
            1: return base + 16'($urandom_range(0, 64)) - 16'd32;
            default: return base;
        endcase
    endfunction

    // A set of the given size; mode picks spread-out, clustered or identical
    // coordinates.
    task automatic queue_set(int size, int mode);
        vertex_req_t v;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        bx = 16'($urandom);
        by = 16'($urandom);
        bz = 16'($urandom);
        for (int i = 0; i < size; i++)
        begin
            v.x = rand_coord(mode, bx);
            v.y = rand_coord(mode, by);
            v.z = rand_coord(mode, bz);
            v.last = (i == size - 1);
            pending_q.push_back(v);
        end
    endtask

    task automatic queue_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit last);
        vertex_req_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        pending_q.push_back(v);
    endtask

    // Traffic phase follows progress through the stimulus.
    function automatic int traffic_phase();
        return (total_requests == 0) ? 0 : (accepted * 4) / total_requests;
    endfunction

    function automatic bit sender_idles();
        int ph;
        ph = traffic_phase();
        if (ph == 1)
            return $urandom_range(0, 99) < 82;
        if (ph == 3)
            return $urandom_range(0, 99) < 34;
        return 1'b0;
    endfunction

    initial
    begin
        int size;
        int mode;
        // Directed sets. A lone vertex has zero radius.
        queue_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        // Two opposite extremes give the largest offsets and radius.
        queue_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        // Identical vertices: zero radius over several results.
        queue_vertex(16'h1234, 16'hFEDC, 16'h0001, 1'b0);
        queue_vertex(16'h1234, 16'hFEDC, 16'h0001, 1'b0);
        queue_vertex(16'h1234, 16'hFEDC, 16'h0001, 1'b1);
        // Negative sums, and a sum that does not divide evenly, check the signed centroid divide.
        queue_vertex(16'hFFFF, 16'h0001, 16'hFFFE, 1'b0);
        queue_vertex(16'hFFFE, 16'h0000, 16'h0000, 1'b0);
        queue_vertex(16'h0000, 16'h0001, 16'hFFFF, 1'b1);
        // A full store, then a store with more vertices than it holds so that
        // the final vertex arrives while the store is full.
        queue_set(32, 0);
        queue_set(35, 1);
        // Random sets: mostly small, a few at or past capacity.
        while (pending_q.size() < 370)
        begin
            case ($urandom_range(0, 19))
                0: size = 32;
                1: size = $urandom_range(33, 36);
                default: size = $urandom_range(1, 6);
            endcase
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
            queue_set(size, mode);
        end
        total_requests = pending_q.size();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0 && scaled_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS centroid_radius_unit_scaling_core");
        else
            $display("FAIL centroid_radius_unit_scaling_core");
        $finish;
    end

    // Driver: the head of the pending queue is on the bus while tvalid is high.
    always @(posedge clk)
    begin
        bit take;
        bit present;
        if (rst_n)
        begin
            take = s_tvalid && s_tready;
            if (take)
            begin
                absorb_vertex(pending_q[0]);
                void'(pending_q.pop_front());
                accepted++;
            end
            if (!s_tvalid || take)
            begin
                present = (pending_q.size() != 0) && !sender_idles();
                s_tvalid <= present;
                if (present)
                begin
                    s_tdata <= {pending_q[0].z, pending_q[0].y, pending_q[0].x};
                    s_tlast <= pending_q[0].last;
                end
            end
        end
    end

    // Receiver readiness: stalls only in the third and fourth phases.
    always @(posedge clk)
    begin
        int ph;
        ph = traffic_phase();
        if (ph == 2)
            m_tready <= $urandom_range(0, 99) >= 82;
        else if (ph == 3)
            m_tready <= $urandom_range(0, 99) >= 34;
        else
            m_tready <= 1'b1;
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // Monitor: each result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        scaled_vertex_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (scaled_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $realtime,
                         m_tdata);
                errors++;
            end
            else
            begin
                e = scaled_q.pop_front();
                check_field("vertex_index", e.index, m_tdata[4:0]);
                check_field("scaled_x", e.sx, m_tdata[20:5]);
                check_field("scaled_y", e.sy, m_tdata[36:21]);
                check_field("scaled_z", e.sz, m_tdata[52:37]);
                check_field("centroid_x", e.cx, m_tdata[68:53]);
                check_field("centroid_y", e.cy, m_tdata[84:69]);
                check_field("centroid_z", e.cz, m_tdata[100:85]);
                check_field("bound_radius", e.radius, m_tdata[117:101]);
                check_field("radius_zero", e.radius_zero, m_tuser[0]);
                check_field("dropped_any", e.dropped, m_tuser[1]);
                check_field("last_result", e.last, m_tlast);
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL centroid_radius_unit_scaling_core");
            $finish;
        end
    end

endmodule
